>>> sv/aesc_pkg.sv
// ----------------------------------------------------------------------------
// aesc_pkg: shared types and constants of the ANSI escape stripper
// Parser modes, character codes, controller/datapath handshake structs and
// the small decode helpers used by the datapath.
// ----------------------------------------------------------------------------
package aesc_pkg;

	// Intermediate byte buffer depth and derived widths
	localparam int MAX_INTER = 8;
	localparam int CNT_W     = $clog2(MAX_INTER + 1);
	localparam int IDX_W     = (MAX_INTER > 1) ? $clog2(MAX_INTER) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_INTER);

	// Character codes
	localparam logic [7:0] CH_BEL  = 8'h07;
	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_RBR  = 8'h5D;
	localparam logic [7:0] C1_DCS  = 8'h90;
	localparam logic [7:0] C1_SOS  = 8'h98;
	localparam logic [7:0] C1_CSI  = 8'h9B;
	localparam logic [7:0] C1_ST   = 8'h9C;
	localparam logic [7:0] C1_OSC  = 8'h9D;
	localparam logic [7:0] C1_PM   = 8'h9E;
	localparam logic [7:0] C1_APC  = 8'h9F;

	// Byte classes
	localparam logic [7:0] INT_LO  = 8'h20;
	localparam logic [7:0] INT_HI  = 8'h2F;
	localparam logic [7:0] PAR_LO  = 8'h30;
	localparam logic [7:0] PAR_HI  = 8'h3F;
	localparam logic [7:0] FIN_LO  = 8'h40;
	localparam logic [7:0] FIN_HI  = 8'h7E;

	// Parser modes
	typedef enum logic [3:0] {
		M_NORMAL     = 4'd0,
		M_ESC        = 4'd1,
		M_CSI_PAR    = 4'd2,
		M_CSI_INT    = 4'd3,
		M_OSC        = 4'd4,
		M_OSC_ESC    = 4'd5,
		M_STR        = 4'd6,
		M_STR_ESC    = 4'd7,
		M_PREFIX     = 4'd8,
		M_C1_CSI     = 4'd9,
		M_C1_OSC     = 4'd10,
		M_C1_OSC_ESC = 4'd11,
		M_C1_STR     = 4'd12,
		M_C1_STR_ESC = 4'd13
	} mode_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_FLUSH = 2'd1,
		S_TAIL  = 2'd2
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;      // take the input request
		logic flush_emit;  // put next buffered intermediate on the output
		logic tail_emit;   // put the held trailing byte on the output
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;    // output register empty or being taken
		logic dec_flush;   // current request opens an intermediate flush
		logic flush_more;  // more intermediates after the current one
		logic tail_pend;   // a trailing byte follows the flush
	} dp_sts_t;

	// Known CSI final bytes
	function automatic logic is_known_final(input logic [7:0] b);
		logic k;
		case (b)
			8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
			8'h66, 8'h4A, 8'h4B, 8'h53, 8'h54,
			8'h6D, 8'h6E, 8'h73, 8'h75: k = 1'b1;
			default: k = 1'b0;
		endcase
		return k;
	endfunction

	// Next mode inside an OSC or string body, or right after its ESC
	function automatic mode_t str_step(input logic [7:0] b, input logic after_esc,
			input logic bel_ends, input logic c1_st, input mode_t body, input mode_t esc);
		mode_t m;
		m = body;
		if (after_esc && b == CH_BSL) begin
			m = M_NORMAL;
		end else if (b == CH_ESC) begin
			m = esc;
		end else if (bel_ends && b == CH_BEL) begin
			m = M_NORMAL;
		end else if (c1_st && b == C1_ST) begin
			m = M_NORMAL;
		end
		return m;
	endfunction

endpackage

>>> sv/aesc_dp.sv
// ----------------------------------------------------------------------------
// aesc_dp: parser datapath of the ANSI escape stripper
// Decodes each request against the parser mode, keeps the intermediate
// buffer, and owns the output register that the controller loads.
// ----------------------------------------------------------------------------
module aesc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  logic                 end_marker,
	input  logic                 out_ready,
	input  aesc_pkg::ctrl_cmd_t  cmd,
	output aesc_pkg::dp_sts_t    sts,
	output logic                 out_valid,
	output logic [7:0]           out_byte,
	output logic                 byte_valid,
	output logic                 run_last,
	output logic                 text_done,
	output logic                 inter_overflow
);

	// Parser state
	aesc_pkg::mode_t                 mode_q;
	logic [aesc_pkg::CNT_W-1:0]      cnt_q;
	logic [7:0]                      inter_q [aesc_pkg::MAX_INTER];

	// Flush bookkeeping for the request in progress
	logic [aesc_pkg::CNT_W-1:0]      len_q;
	logic [aesc_pkg::CNT_W-1:0]      idx_q;
	logic                            tail_q;
	logic [7:0]                      tail_byte_q;
	logic                            tail_bv_q;
	logic                            end_q;
	logic                            ovf_q;

	// Output register
	logic                            out_valid_q;
	logic [7:0]                      out_byte_q;
	logic                            byte_valid_q;
	logic                            run_last_q;
	logic                            text_done_q;
	logic                            ovf_out_q;

	// Decode results
	aesc_pkg::mode_t                 nb_mode;
	logic                            nb_emit;
	aesc_pkg::mode_t                 dec_nxt;
	logic                            dec_push;
	logic                            dec_clr;
	logic                            dec_fl;
	logic                            dec_em;
	logic                            dec_ovf;
	logic [7:0]                      dec_byte;
	logic                            dec_bv;

	logic                            out_free;
	logic                            flush_more;
	logic                            load_direct;
	logic                            load_any;
	logic                            flush_last;

	// Plain text byte: C1 introducers and ESC open sequences, the rest is kept
	always_comb begin
		nb_mode = aesc_pkg::M_NORMAL;
		nb_emit = 1'b0;
		case (data_byte)
			aesc_pkg::CH_ESC: nb_mode = aesc_pkg::M_ESC;
			aesc_pkg::C1_CSI: nb_mode = aesc_pkg::M_C1_CSI;
			aesc_pkg::C1_OSC: nb_mode = aesc_pkg::M_C1_OSC;
			aesc_pkg::C1_DCS, aesc_pkg::C1_SOS,
			aesc_pkg::C1_PM, aesc_pkg::C1_APC: nb_mode = aesc_pkg::M_C1_STR;
			default: nb_emit = 1'b1;
		endcase
	end

	// Request decode against the current mode
	always_comb begin
		dec_nxt  = mode_q;
		dec_push = 1'b0;
		dec_clr  = 1'b0;
		dec_fl   = 1'b0;
		dec_em   = 1'b0;
		dec_ovf  = 1'b0;
		dec_byte = data_byte;
		dec_bv   = 1'b1;
		if (end_marker) begin
			// end of text: flush open CSI intermediates, else one empty result
			dec_fl   = (mode_q == aesc_pkg::M_CSI_INT) && (cnt_q != '0);
			dec_em   = !dec_fl;
			dec_byte = 8'h00;
			dec_bv   = 1'b0;
			dec_clr  = 1'b1;
			dec_nxt  = aesc_pkg::M_NORMAL;
		end else begin
			case (mode_q)
				aesc_pkg::M_ESC: begin
					case (data_byte)
						aesc_pkg::CH_LBR: begin
							dec_nxt = aesc_pkg::M_CSI_PAR;
							dec_clr = 1'b1;
						end
						aesc_pkg::CH_RBR: dec_nxt = aesc_pkg::M_OSC;
						8'h50, 8'h58, 8'h5E, 8'h5F: dec_nxt = aesc_pkg::M_STR;
						8'h23, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h20:
							dec_nxt = aesc_pkg::M_PREFIX;
						default: dec_nxt = aesc_pkg::M_NORMAL;
					endcase
				end
				aesc_pkg::M_CSI_PAR, aesc_pkg::M_CSI_INT: begin
					if (mode_q == aesc_pkg::M_CSI_PAR &&
							data_byte inside {[aesc_pkg::PAR_LO:aesc_pkg::PAR_HI]}) begin
						dec_nxt = mode_q;
					end else if (data_byte inside {[aesc_pkg::INT_LO:aesc_pkg::INT_HI]}) begin
						if (cnt_q < aesc_pkg::MAX_CNT) begin
							dec_push = 1'b1;
							dec_nxt  = aesc_pkg::M_CSI_INT;
						end else begin
							// buffer full: flush it, keep this byte as text
							dec_fl  = 1'b1;
							dec_clr = 1'b1;
							dec_nxt = nb_mode;
							dec_em  = nb_emit;
							dec_ovf = 1'b1;
						end
					end else if (data_byte inside {[aesc_pkg::FIN_LO:aesc_pkg::FIN_HI]} &&
							aesc_pkg::is_known_final(data_byte)) begin
						dec_clr = 1'b1;
						dec_nxt = aesc_pkg::M_NORMAL;
					end else begin
						// unknown final or breaking byte
						dec_fl  = (cnt_q != '0);
						dec_clr = 1'b1;
						dec_nxt = nb_mode;
						dec_em  = nb_emit;
					end
				end
				aesc_pkg::M_OSC:
					dec_nxt = aesc_pkg::str_step(data_byte, 1'b0, 1'b1, 1'b0,
						aesc_pkg::M_OSC, aesc_pkg::M_OSC_ESC);
				aesc_pkg::M_OSC_ESC:
					dec_nxt = aesc_pkg::str_step(data_byte, 1'b1, 1'b1, 1'b0,
						aesc_pkg::M_OSC, aesc_pkg::M_OSC_ESC);
				aesc_pkg::M_STR:
					dec_nxt = aesc_pkg::str_step(data_byte, 1'b0, 1'b0, 1'b0,
						aesc_pkg::M_STR, aesc_pkg::M_STR_ESC);
				aesc_pkg::M_STR_ESC:
					dec_nxt = aesc_pkg::str_step(data_byte, 1'b1, 1'b0, 1'b0,
						aesc_pkg::M_STR, aesc_pkg::M_STR_ESC);
				aesc_pkg::M_PREFIX: dec_nxt = aesc_pkg::M_NORMAL;
				aesc_pkg::M_C1_CSI: begin
					if (data_byte inside {[aesc_pkg::FIN_LO:aesc_pkg::FIN_HI]}) begin
						dec_nxt = aesc_pkg::M_NORMAL;
					end
				end
				aesc_pkg::M_C1_OSC:
					dec_nxt = aesc_pkg::str_step(data_byte, 1'b0, 1'b1, 1'b1,
						aesc_pkg::M_C1_OSC, aesc_pkg::M_C1_OSC_ESC);
				aesc_pkg::M_C1_OSC_ESC:
					dec_nxt = aesc_pkg::str_step(data_byte, 1'b1, 1'b1, 1'b1,
						aesc_pkg::M_C1_OSC, aesc_pkg::M_C1_OSC_ESC);
				aesc_pkg::M_C1_STR:
					dec_nxt = aesc_pkg::str_step(data_byte, 1'b0, 1'b0, 1'b1,
						aesc_pkg::M_C1_STR, aesc_pkg::M_C1_STR_ESC);
				aesc_pkg::M_C1_STR_ESC:
					dec_nxt = aesc_pkg::str_step(data_byte, 1'b1, 1'b0, 1'b1,
						aesc_pkg::M_C1_STR, aesc_pkg::M_C1_STR_ESC);
				default: begin
					dec_nxt = nb_mode;
					dec_em  = nb_emit;
				end
			endcase
		end
	end

	// Status and output load selects
	assign out_free    = !out_valid_q || out_ready;
	assign flush_more  = aesc_pkg::CNT_W'(idx_q + 1'b1) != len_q;
	assign flush_last  = !flush_more && !tail_q;
	assign load_direct = cmd.accept && !dec_fl && dec_em;
	assign load_any    = load_direct || cmd.flush_emit || cmd.tail_emit;

	assign sts.out_free   = out_free;
	assign sts.dec_flush  = dec_fl;
	assign sts.flush_more = flush_more;
	assign sts.tail_pend  = tail_q;

	// Control state: mode, fill count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= aesc_pkg::M_NORMAL;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				mode_q <= dec_nxt;
				if (dec_clr) begin
					cnt_q <= '0;
				end else if (dec_push) begin
					cnt_q <= aesc_pkg::CNT_W'(cnt_q + 1'b1);
				end
			end
			if (load_any) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Intermediate buffer write
	always_ff @(posedge clk) begin
		if (cmd.accept && dec_push) begin
			inter_q[cnt_q[aesc_pkg::IDX_W-1:0]] <= data_byte;
		end
	end

	// Flush bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			len_q       <= cnt_q;
			idx_q       <= '0;
			tail_q      <= dec_em;
			tail_byte_q <= dec_byte;
			tail_bv_q   <= dec_bv;
			end_q       <= end_marker;
			ovf_q       <= dec_ovf;
		end else if (cmd.flush_emit) begin
			idx_q <= aesc_pkg::CNT_W'(idx_q + 1'b1);
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_direct) begin
			out_byte_q   <= dec_byte;
			byte_valid_q <= dec_bv;
			run_last_q   <= 1'b1;
			text_done_q  <= end_marker;
			ovf_out_q    <= dec_ovf;
		end else if (cmd.flush_emit) begin
			out_byte_q   <= inter_q[idx_q[aesc_pkg::IDX_W-1:0]];
			byte_valid_q <= 1'b1;
			run_last_q   <= flush_last;
			text_done_q  <= flush_last && end_q;
			ovf_out_q    <= ovf_q;
		end else if (cmd.tail_emit) begin
			out_byte_q   <= tail_byte_q;
			byte_valid_q <= tail_bv_q;
			run_last_q   <= 1'b1;
			text_done_q  <= end_q;
			ovf_out_q    <= ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign byte_valid     = byte_valid_q;
	assign run_last       = run_last_q;
	assign text_done      = text_done_q;
	assign inter_overflow = ovf_out_q;

	// Fill count stays within the buffer
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= aesc_pkg::MAX_CNT)
		else $error("intermediate count beyond buffer depth");

	// Intermediate mode always has something buffered
	a_int_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == aesc_pkg::M_CSI_INT |-> cnt_q != '0)
		else $error("intermediate mode with empty buffer");

	// Flush reads only entries of the current run
	a_flush_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_emit |-> idx_q < len_q)
		else $error("flush read past buffered intermediates");

	// An end request leaves the parser in normal text mode
	a_end_normal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && end_marker |=> mode_q == aesc_pkg::M_NORMAL && cnt_q == '0)
		else $error("end request did not reset the parser");

endmodule

>>> sv/aesc_ctrl.sv
// ----------------------------------------------------------------------------
// aesc_ctrl: sequencing controller of the ANSI escape stripper
// Takes requests when the output register is free and steps the datapath
// through intermediate flushes and the trailing byte.
// ----------------------------------------------------------------------------
module aesc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  aesc_pkg::dp_sts_t    sts,
	output aesc_pkg::ctrl_cmd_t  cmd
);

	aesc_pkg::ctrl_state_t state_q;
	aesc_pkg::ctrl_state_t state_nxt;
	logic                  accept;

	assign accept = in_valid && in_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			aesc_pkg::S_IDLE: begin
				if (accept && sts.dec_flush) begin
					state_nxt = aesc_pkg::S_FLUSH;
				end
			end
			aesc_pkg::S_FLUSH: begin
				if (sts.out_free && !sts.flush_more) begin
					state_nxt = sts.tail_pend ? aesc_pkg::S_TAIL : aesc_pkg::S_IDLE;
				end
			end
			aesc_pkg::S_TAIL: begin
				if (sts.out_free) begin
					state_nxt = aesc_pkg::S_IDLE;
				end
			end
			default: state_nxt = aesc_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready       = 1'b0;
		cmd.accept     = 1'b0;
		cmd.flush_emit = 1'b0;
		cmd.tail_emit  = 1'b0;
		case (state_q)
			aesc_pkg::S_IDLE: begin
				in_ready   = sts.out_free;
				cmd.accept = in_valid && sts.out_free;
			end
			aesc_pkg::S_FLUSH: cmd.flush_emit = sts.out_free;
			aesc_pkg::S_TAIL:  cmd.tail_emit  = sts.out_free;
			default: in_ready = 1'b0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aesc_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// A flushing request moves into the flush sequence
	a_to_flush: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sts.dec_flush |=> state_q == aesc_pkg::S_FLUSH)
		else $error("flush request did not start flush");

	// Emits happen only with a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_emit || cmd.tail_emit |-> sts.out_free)
		else $error("emit into occupied output register");

	// No request taken while a flush or trailing byte is pending
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != aesc_pkg::S_IDLE |-> !cmd.accept)
		else $error("request taken while busy");

endmodule

>>> sv/ansi_escape_stripper.sv
// Output: a directly kept byte or an empty end result is registered and shows on the cycle after
// acceptance; flushed intermediates follow one per cycle while the output register is free.
// Throughput: one byte per cycle while no intermediates are flushed and out_ready holds; a
// request that flushes buffered CSI intermediates blocks input until they and any trailing
// byte have passed through the single output register that the flush walks through.
// Reset (arst_n low): normal text mode, empty buffer, empty output register.
// ----------------------------------------------------------------------------
// ansi_escape_stripper: removes ECMA-48 control sequences from a byte stream
// Controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
module ansi_escape_stripper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_marker,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       text_done,
	output logic       inter_overflow
);

	aesc_pkg::ctrl_cmd_t cmd;
	aesc_pkg::dp_sts_t   sts;

	// Sequencing controller
	aesc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Parser datapath and output register
	aesc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_byte      (data_byte),
		.end_marker     (end_marker),
		.out_ready      (out_ready),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.run_last       (run_last),
		.text_done      (text_done),
		.inter_overflow (inter_overflow)
	);

endmodule
